// File: hdl/blr_pkg.sv
// shared widths and item types for the line rasterizer
package blr_pkg;

    localparam int COORD_BITS = 11;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int EXT_BITS   = DEC_BITS - COORD_BITS;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t  mode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } blr_cmd_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } blr_pix_t;

endpackage

// File: hdl/blr_cmd_if.sv
// command channel carrying line loads and step requests
interface blr_cmd_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: hdl/blr_pix_if.sv
// pixel channel carrying rasterized points
interface blr_pix_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// File: hdl/blr_core.sv
// line state registers with endpoint setup and per-pixel midpoint step
module blr_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  blr_pkg::blr_cmd_t cmd,
    output logic              res_valid,
    output blr_pkg::blr_pix_t res
);
    import blr_pkg::*;

    coord_t cur_major_reg,   cur_major_next;
    coord_t cur_minor_reg,   cur_minor_next;
    coord_t major_delta_reg, major_delta_next;
    coord_t minor_delta_reg, minor_delta_next;
    dec_t   decision_reg,    decision_next;
    logic   minor_down_reg,  minor_down_next;
    logic   steep_reg,       steep_next;
    coord_t pixels_left_reg, pixels_left_next;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    coord_t adx;
    coord_t ady;
    logic   shallow;
    coord_t ld_major;
    coord_t ld_minor;
    coord_t ld_maj_delta;
    coord_t ld_min_delta;
    logic   ld_down;
    dec_t   min2;
    dec_t   maj2;
    dec_t   ld_min2;
    dec_t   ld_maj;
    logic   do_step;
    coord_t step_minor;

    // endpoint setup
    always_comb
    begin
        dx      = $signed({1'b0, cmd.end_x}) - $signed({1'b0, cmd.start_x});
        dy      = $signed({1'b0, cmd.end_y}) - $signed({1'b0, cmd.start_y});
        adx     = dx[COORD_BITS] ? coord_t'(-dx) : coord_t'(dx);
        ady     = dy[COORD_BITS] ? coord_t'(-dy) : coord_t'(dy);
        shallow = adx > ady;
        if (shallow)
        begin
            ld_maj_delta = adx;
            ld_min_delta = ady;
            if (dx[COORD_BITS])
            begin
                ld_major = cmd.end_x;
                ld_minor = cmd.end_y;
                ld_down  = (dy > 0);
            end
            else
            begin
                ld_major = cmd.start_x;
                ld_minor = cmd.start_y;
                ld_down  = dy[COORD_BITS];
            end
        end
        else
        begin
            ld_maj_delta = ady;
            ld_min_delta = adx;
            if (dy[COORD_BITS])
            begin
                ld_major = cmd.end_y;
                ld_minor = cmd.end_x;
                ld_down  = (dx > 0);
            end
            else
            begin
                ld_major = cmd.start_y;
                ld_minor = cmd.start_x;
                ld_down  = dx[COORD_BITS];
            end
        end
        ld_min2 = $signed({{(EXT_BITS-1){1'b0}}, ld_min_delta, 1'b0});
        ld_maj  = $signed({{EXT_BITS{1'b0}}, ld_maj_delta});
    end

    // midpoint step
    always_comb
    begin
        min2    = $signed({{(EXT_BITS-1){1'b0}}, minor_delta_reg, 1'b0});
        maj2    = $signed({{(EXT_BITS-1){1'b0}}, major_delta_reg, 1'b0});
        do_step = go && (cmd.mode == MODE_STEP) && (pixels_left_reg != '0);

        cur_major_next   = cur_major_reg;
        cur_minor_next   = cur_minor_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        decision_next    = decision_reg;
        minor_down_next  = minor_down_reg;
        steep_next       = steep_reg;
        pixels_left_next = pixels_left_reg;
        step_minor       = cur_minor_reg;

        if (!decision_reg[DEC_BITS-1])
        begin
            step_minor = minor_down_reg ? cur_minor_reg - 1'b1 : cur_minor_reg + 1'b1;
        end

        if (go && (cmd.mode == MODE_LOAD))
        begin
            cur_major_next   = ld_major;
            cur_minor_next   = ld_minor;
            major_delta_next = ld_maj_delta;
            minor_delta_next = ld_min_delta;
            decision_next    = ld_min2 - ld_maj;
            minor_down_next  = ld_down;
            steep_next       = !shallow;
            pixels_left_next = ld_maj_delta;
        end
        else if (do_step)
        begin
            cur_major_next   = cur_major_reg + 1'b1;
            cur_minor_next   = step_minor;
            decision_next    = decision_reg[DEC_BITS-1] ? decision_reg + min2
                                                        : decision_reg - maj2 + min2;
            pixels_left_next = pixels_left_reg - 1'b1;
        end
    end

    always_comb
    begin
        res_valid      = do_step;
        res.last_pixel = (pixels_left_reg == coord_t'(1));
        if (steep_reg)
        begin
            res.pixel_x = step_minor;
            res.pixel_y = cur_major_reg + 1'b1;
        end
        else
        begin
            res.pixel_x = cur_major_reg + 1'b1;
            res.pixel_y = step_minor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_major_reg   <= '0;
            cur_minor_reg   <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            decision_reg    <= '0;
            minor_down_reg  <= 1'b0;
            steep_reg       <= 1'b0;
            pixels_left_reg <= '0;
        end
        else
        begin
            cur_major_reg   <= cur_major_next;
            cur_minor_reg   <= cur_minor_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            decision_reg    <= decision_next;
            minor_down_reg  <= minor_down_next;
            steep_reg       <= steep_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

`ifndef SYNTHESIS
    a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        minor_delta_reg <= major_delta_reg)
        else $error("minor delta exceeds major delta");

    a_decision_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels_left_reg != '0) |-> (decision_reg >= -maj2) && (decision_reg < min2))
        else $error("decision term out of range");

    a_left_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_left_reg <= major_delta_reg)
        else $error("more pixels left than the line holds");
`endif

endmodule

// File: hdl/bresenham_line_rasterizer.sv
// bresenham line rasterizer top level: command register, line core, pixel register
// a step item is held in the command register, then its pixel is registered in the pixel register
// throughput: one item per cycle while the pixel sink keeps ready high
// load items update the line registers in the core and produce no pixel
// reset (asynchronous, active low) clears both stage valids and leaves no line active
module bresenham_line_rasterizer
(
    input  logic       clk,
    input  logic       rst_n,
    blr_cmd_if.sink    cmd,
    blr_pix_if.source  pix
);
    import blr_pkg::*;

    blr_cmd_t s1_reg;
    logic     s1_valid_reg;
    blr_pix_t out_reg;
    logic     out_valid_reg;
    logic     exec_go;
    logic     res_valid;
    blr_pix_t res;

    assign exec_go   = s1_valid_reg && (!out_valid_reg || pix.ready);
    assign cmd.ready = !s1_valid_reg || exec_go;

    blr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (exec_go),
        .cmd       (s1_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_reg.mode    <= mode_t'(cmd.mode);
            s1_reg.start_x <= cmd.start_x;
            s1_reg.start_y <= cmd.start_y;
            s1_reg.end_x   <= cmd.end_x;
            s1_reg.end_y   <= cmd.end_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= res_valid;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = out_reg.pixel_x;
    assign pix.pixel_y    = out_reg.pixel_y;
    assign pix.last_pixel = out_reg.last_pixel;

`ifndef SYNTHESIS
    a_stall_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !exec_go) |=> s1_valid_reg && $stable(s1_reg))
        else $error("pending command lost while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> s1_valid_reg)
        else $error("command channel blocked with empty stage");

    a_pixel_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pix.ready) |=> out_valid_reg && $stable(out_reg))
        else $error("waiting pixel overwritten");
`endif

endmodule

// File: tb/blr_checker.sv
// pixel predictor and checker for the line rasterizer channels
`timescale 1ns / 100ps

module blr_checker
(
    input  logic clk,
    input  logic rst_n,
    blr_cmd_if   cmd,
    blr_pix_if   pix,
    output int   fail_count,
    output int   outstanding,
    output int   pixels_checked
);
    import blr_pkg::*;

    coord_t cur_major;
    coord_t cur_minor;
    coord_t major_delta;
    coord_t minor_delta;
    coord_t pixels_left;
    int     decision_term;
    bit     minor_goes_down;
    bit     steep_line;

    blr_pix_t pending_pixels[$];

    function automatic void load_line(input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey);
        int dx;
        int dy;
        int adx;
        int ady;
        int dmaj;
        int dmin;
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (adx > ady)
        begin
            steep_line = 1'b0;
            if (dx < 0)
            begin
                cur_major = ex;
                cur_minor = ey;
                dmaj      = -dx;
                dmin      = -dy;
            end
            else
            begin
                cur_major = sx;
                cur_minor = sy;
                dmaj      = dx;
                dmin      = dy;
            end
        end
        else
        begin
            steep_line = 1'b1;
            if (dy < 0)
            begin
                cur_major = ey;
                cur_minor = ex;
                dmaj      = -dy;
                dmin      = -dx;
            end
            else
            begin
                cur_major = sy;
                cur_minor = sx;
                dmaj      = dy;
                dmin      = dx;
            end
        end
        major_delta     = coord_t'(dmaj);
        minor_goes_down = (dmin < 0);
        minor_delta     = coord_t'((dmin < 0) ? -dmin : dmin);
        decision_term   = 2 * int'(minor_delta) - int'(major_delta);
        pixels_left     = major_delta;
    endfunction

    function automatic void trace_step();
        blr_pix_t px;
        if (pixels_left == '0)
            return;
        if (decision_term >= 0)
        begin
            cur_minor     = minor_goes_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
            decision_term = decision_term - 2 * int'(major_delta);
        end
        cur_major     = cur_major + 1'b1;
        decision_term = decision_term + 2 * int'(minor_delta);
        pixels_left   = pixels_left - 1'b1;
        px.pixel_x    = steep_line ? cur_minor : cur_major;
        px.pixel_y    = steep_line ? cur_major : cur_minor;
        px.last_pixel = (pixels_left == '0);
        pending_pixels = {pending_pixels, px};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        blr_pix_t want;
        if (!rst_n)
        begin
            cur_major       = '0;
            cur_minor       = '0;
            major_delta     = '0;
            minor_delta     = '0;
            pixels_left     = '0;
            decision_term   = 0;
            minor_goes_down = 1'b0;
            steep_line      = 1'b0;
            pending_pixels.delete();
            fail_count      = 0;
            pixels_checked  = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                             pix.pixel_x, pix.pixel_y, pix.last_pixel);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (pix.pixel_x !== want.pixel_x)
                    begin
                        $display("%0t: pixel_x expected %0d got %0d", $time,
                                 want.pixel_x, pix.pixel_x);
                        fail_count++;
                    end
                    if (pix.pixel_y !== want.pixel_y)
                    begin
                        $display("%0t: pixel_y expected %0d got %0d", $time,
                                 want.pixel_y, pix.pixel_y);
                        fail_count++;
                    end
                    if (pix.last_pixel !== want.last_pixel)
                    begin
                        $display("%0t: last_pixel expected %0b got %0b", $time,
                                 want.last_pixel, pix.last_pixel);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                if (mode_t'(cmd.mode) == MODE_LOAD)
                    load_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
                else
                    trace_step();
            end
        end
        outstanding = pending_pixels.size();
    end

endmodule

// File: tb/testbench.sv
// stimulus, clocking and verdict for the line rasterizer
`timescale 1ns / 100ps

module testbench;
    import blr_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    blr_cmd_if cmd_ch();
    blr_pix_if pix_ch();

    int fail_count;
    int outstanding;
    int pixels_checked;
    int items_sent;
    int lines_loaded;
    bit sender_idles;
    bit quiet_tail;
    bit squeeze_req;

    bresenham_line_rasterizer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch)
    );

    blr_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .pix            (pix_ch),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input mode_t m, input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= m;
        cmd_ch.start_x <= sx;
        cmd_ch.start_y <= sy;
        cmd_ch.end_x   <= ex;
        cmd_ch.end_y   <= ey;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
        if (m == MODE_LOAD)
            lines_loaded++;
    endtask

    task automatic load_item(input int sx, input int sy, input int ex, input int ey);
        send_item(MODE_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    endtask

    // step items carry junk endpoints that the block must ignore
    task automatic step_item();
        send_item(MODE_STEP, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
    endtask

    function automatic coord_t offset_coord(input coord_t s, input int d);
        if ($urandom_range(0, 1) && int'(s) >= d)
            return coord_t'(int'(s) - d);
        else if (int'(s) + d <= COORD_MAX)
            return coord_t'(int'(s) + d);
        else
            return coord_t'(int'(s) - d);
    endfunction

    task automatic draw_random_line(input int max_len);
        int     len;
        int     minor;
        int     steps;
        bit     steep;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        len   = $urandom_range(0, max_len);
        minor = ($urandom_range(0, 9) == 0) ? len : $urandom_range(0, len);
        steep = 1'($urandom_range(0, 1));
        sx    = coord_t'($urandom);
        sy    = coord_t'($urandom);
        ex    = offset_coord(sx, steep ? minor : len);
        ey    = offset_coord(sy, steep ? len : minor);
        send_item(MODE_LOAD, sx, sy, ex, ey);
        steps = len + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            steps = $urandom_range(0, len);
        repeat (steps) step_item();
    endtask

    // receiver: random stall bursts in bursty windows, one long hold-off on request
    initial
    begin
        int  window;
        bit  calm;
        bit  squeezed;
        window   = 0;
        calm     = 1'b0;
        squeezed = 1'b0;
        pix_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            window++;
            if (window >= 150)
            begin
                window = 0;
                calm   = $urandom_range(0, 2) == 0;
            end
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pix_ch.ready <= 1'b1;
            end
            else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                pix_ch.ready <= 1'b1;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int random_items;
        items_sent   = 0;
        lines_loaded = 0;
        sender_idles = 1'b1;
        quiet_tail   = 1'b0;
        squeeze_req  <= 1'b0;
        rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.mode    <= MODE_LOAD;
        cmd_ch.start_x <= '0;
        cmd_ch.start_y <= '0;
        cmd_ch.end_x   <= '0;
        cmd_ch.end_y   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line active, then a zero-length line
        step_item();
        load_item(0, 0, 0, 0);
        step_item();
        // shallow, drawn right to left, minor axis falling, plus a step past the end
        load_item(COORD_MAX, 0, COORD_MAX - 4, 2);
        repeat (5) step_item();
        // equal deltas count as steep, minor axis falling
        load_item(0, COORD_MAX, 3, COORD_MAX - 3);
        repeat (3) step_item();
        // exact tie steps diagonally
        load_item(10, 10, 12, 11);
        repeat (2) step_item();
        // full-extent line replaced mid-way by a vertical one
        load_item(0, 0, COORD_MAX, COORD_MAX);
        step_item();
        load_item(100, 200, 100, 203);
        repeat (3) step_item();
        load_item(0, COORD_MAX, COORD_MAX, 0);
        step_item();

        // longest shallow line while the receiver holds off
        squeeze_req <= 1'b1;
        load_item(0, int'(coord_t'($urandom)), COORD_MAX, int'(coord_t'($urandom)));
        repeat (200) step_item();

        random_items = 0;
        while (random_items < 950)
        begin
            if (random_items >= 800)
            begin
                sender_idles = 1'b0;
                quiet_tail   = 1'b1;
            end
            else
            begin
                sender_idles = $urandom_range(0, 2) != 0;
            end
            items_sent = 0;
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(mode_t'($urandom_range(0, 1)), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom));
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                draw_random_line(300);
            end
            else
            begin
                draw_random_line(24);
            end
            random_items += items_sent;
        end

        cmd_ch.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d loads (shallow, steep, reversed, tied, zero-length, replaced)",
                 lines_loaded);
        $display("%0d pixels compared, including a full-width line under a long stall",
                 pixels_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hdl/blr_pkg.sv
hdl/blr_cmd_if.sv
hdl/blr_pix_if.sv
hdl/blr_core.sv
hdl/bresenham_line_rasterizer.sv
tb/blr_checker.sv
tb/testbench.sv
